// File: rtl/sdcp_pkg.sv
// Shared constants, types and helper functions for the serial drive command parser.
// No dependencies.
`default_nettype none
package sdcp_pkg;
   localparam int LINE_MAX_DEFAULT = 64;
   localparam logic [15:0] TIMEOUT_RESET = 16'd400;
   localparam logic [0:0] OP_TICK = 1'b0;
   localparam logic [0:0] OP_BYTE = 1'b1;
   localparam int QUEUE_DEPTH = 2;

   // Number collector states.
   localparam logic [1:0] NUM_WAIT  = 2'd0;  // start of the number not reached
   localparam logic [1:0] NUM_FIRST = 2'd1;  // next kept character is the first
   localparam logic [1:0] NUM_DIG   = 2'd2;  // collecting digits
   localparam logic [1:0] NUM_STOP  = 2'd3;  // number ended

   // ceil(2^23 / 7): exact quotient by seven for dividends below 2^21
   localparam logic [20:0] RECIP_7 = 21'd1198373;

   // Classified event handed from the front end to the back end.
   typedef struct packed {
      logic       is_byte;
      logic       keep;
      logic       newline;
      logic [7:0] ch;
   } event_type;

   // Running decimal value, kept modulo 2^16.
   typedef struct packed {
      logic [1:0]  st;
      logic        neg;
      logic [15:0] acc;
   } num_type;

   localparam num_type NUM_IDLE  = {NUM_WAIT, 1'b0, 16'd0};
   localparam num_type NUM_ARMED = {NUM_FIRST, 1'b0, 16'd0};

   function automatic logic keep_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == "," || c == ":" || c == "-";
   endfunction

   function automatic logic [7:0] upper(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? (c - 8'd32) : c;
   endfunction

   function automatic num_type num_step(input num_type n, input logic [7:0] c);
      num_type r;
      logic    digit;
      digit = (c >= "0" && c <= "9");
      r = n;
      case (n.st)
         NUM_FIRST: begin
            if (c == "-") begin
               r.neg = 1'b1;
               r.st  = NUM_DIG;
            end else if (digit) begin
               r.acc = 16'(c - "0");
               r.st  = NUM_DIG;
            end else begin
               r.st = NUM_STOP;
            end
         end
         NUM_DIG: begin
            if (digit) begin
               r.acc = (n.acc << 3) + (n.acc << 1) + 16'(c - "0");
            end else begin
               r.st = NUM_STOP;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] num_value(input num_type n);
      return n.neg ? (16'd0 - n.acc) : n.acc;
   endfunction
endpackage
`default_nettype wire

// File: rtl/serial_drive_command_parser.sv
// Serial drive command parser, top level.
// Timing: a request is first written into the front queue; the response is registered on the result
// ports at acceptance for a tick, a kept or dropped byte and a CHK or HOME line end; a parsed
// line end then passes through the offset and scale, divide and map states.
// Throughput: one request per cycle while responses are popped at once; a parsed line
// end holds the back end until the map state is done; the front queue holds two requests.
// Synchronous active-high reset clears queue, line, speed, steering, idle count and
// response; timeout resets to 400 ms.
// Depends on sdcp_pkg, sdcp_front, sdcp_back.
`default_nettype none
module serial_drive_command_parser import sdcp_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_rx_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_speed,
   output logic signed [15:0] rsp_steering,
   output logic             rsp_check_reply,
   output logic             rsp_home_request,
   output logic             rsp_line_done,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   logic      ev_valid, ev_take;
   event_type ev_data;

   // front end: classify and queue requests
   sdcp_front u_front (
      .clock, .reset, .push, .full, .req_operation, .req_rx_byte,
      .ev_valid, .ev_data, .ev_take
   );

   // back end: line tracking, parse, steering map, result register
   sdcp_back #(.LINE_MAX(LINE_MAX)) u_back (
      .clock, .reset, .csr_we, .csr_wdata, .ev_valid, .ev_data, .ev_take,
      .empty, .pop, .rsp_speed, .rsp_steering, .rsp_check_reply,
      .rsp_home_request, .rsp_line_done
   );
endmodule
`default_nettype wire

// File: rtl/sdcp_front.sv
// Front end: accepts requests, classifies them, and queues them for the back end.
// Depends on sdcp_pkg.
`default_nettype none
module sdcp_front import sdcp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_rx_byte,
   output logic            ev_valid,
   output event_type       ev_data,
   input  wire logic       ev_take
);
   event_type q_ff [QUEUE_DEPTH];
   logic      wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      do_push;
   event_type ev;

   assign full = (cnt_ff == 2'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign ev_valid = (cnt_ff != 2'd0);
   assign ev_data = q_ff[rd_ff];

   always_comb begin
      ev.is_byte = (req_operation == OP_BYTE);
      ev.keep    = keep_char(req_rx_byte);
      ev.newline = (req_rx_byte == 8'h0a);
      ev.ch      = upper(req_rx_byte);
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = (ev_take && ev_valid) ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(ev_take && ev_valid);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= ev;
      end
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/sdcp_back.sv
// Back end: line tracking, number collection, steering map, command state, result register.
// Depends on sdcp_pkg.
`default_nettype none
module sdcp_back import sdcp_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        ev_valid,
   input  event_type        ev_data,
   output logic             ev_take,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_speed,
   output logic signed [15:0] rsp_steering,
   output logic             rsp_check_reply,
   output logic             rsp_home_request,
   output logic             rsp_line_done
);
   localparam int LW = $clog2(LINE_MAX + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_MAP  = 2'd3;

   logic [1:0]    st_ff;
   logic [LW-1:0] len_ff;
   logic [7:0]    prev_ff;                 // last kept character of the line
   logic          sk_ff, pk_ff;            // key already seen in this line
   logic          m_chk_ff, m_home_ff;     // line so far spells the word
   num_type       one_ff, s_num_ff, p_num_ff;
   num_type       one_in, s_num_in, p_num_in;
   logic [15:0]   tmo_ff, idle_ff, idle_in;
   logic [7:0]    speed_ff;
   logic [15:0]   steer_ff;
   logic [15:0]   pval_ff;
   logic          neg_ff;
   logic [19:0]   mag_ff;
   logic [15:0]   quo_ff;
   logic          full_ff;
   logic [7:0]    o_speed_ff;
   logic [15:0]   o_steer_ff;
   logic          o_chk_ff, o_home_ff, o_done_ff;

   logic          clr, newline_byte, parse_now, store_ch, s_hit, p_hit;
   logic          is_chk, is_home, res_load;
   logic [7:0]    speed_now;
   logic [15:0]   steer_now, s_val, p_val;
   logic signed [16:0] sum;
   logic [16:0]   sum_mag;
   logic [40:0]   prod;
   logic [15:0]   m_signed, mapped;

   assign empty = !full_ff;
   assign rsp_speed = o_speed_ff;
   assign rsp_steering = o_steer_ff;
   assign rsp_check_reply = o_chk_ff;
   assign rsp_home_request = o_home_ff;
   assign rsp_line_done = o_done_ff;

   assign ev_take = (st_ff == ST_IDLE) && ev_valid && (!full_ff || pop);

   assign idle_in = (idle_ff != 16'hffff) ? idle_ff + 16'd1 : idle_ff;
   // a tick checks the advanced count, a byte the count before it
   assign clr = ev_data.is_byte ? (idle_ff >= tmo_ff) : (idle_in >= tmo_ff);
   assign speed_now = clr ? 8'd0 : speed_ff;
   assign steer_now = clr ? 16'd0 : steer_ff;

   assign newline_byte = ev_data.is_byte && ev_data.newline;
   assign store_ch = ev_data.is_byte && ev_data.keep && (len_ff < LW'(LINE_MAX));
   assign is_chk = m_chk_ff && (len_ff == LW'(3));
   assign is_home = m_home_ff && (len_ff == LW'(4));
   assign parse_now = ev_take && newline_byte && !is_chk && !is_home;
   assign res_load = (ev_take && !parse_now) || (st_ff == ST_MAP);

   // first "S:" or "P:" arms its collector for the next kept character
   assign s_hit = !sk_ff && (ev_data.ch == ":") && (prev_ff == "S");
   assign p_hit = !pk_ff && (ev_data.ch == ":") && (prev_ff == "P");
   assign one_in = (len_ff == '0) ? NUM_ARMED : num_step(one_ff, ev_data.ch);
   assign s_num_in = s_hit ? NUM_ARMED : num_step(s_num_ff, ev_data.ch);
   assign p_num_in = p_hit ? NUM_ARMED : num_step(p_num_ff, ev_data.ch);

   // missing key: fall back to the value collected from index one
   assign s_val = sk_ff ? num_value(s_num_ff) : num_value(one_ff);
   assign p_val = pk_ff ? num_value(p_num_ff) : num_value(one_ff);

   // (p+35)*200/70 = (p+35)*20/7, truncated toward zero
   assign sum = signed'({pval_ff[15], pval_ff}) + 17'sd35;
   assign sum_mag = sum[16] ? 17'(-sum) : 17'(sum);
   assign prod = 41'(mag_ff) * 41'(RECIP_7);
   assign m_signed = neg_ff ? (16'd0 - quo_ff) : quo_ff;
   assign mapped = m_signed - 16'd100;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         len_ff <= '0; prev_ff <= '0; sk_ff <= 1'b0; pk_ff <= 1'b0;
         m_chk_ff <= 1'b1; m_home_ff <= 1'b1;
         one_ff <= NUM_IDLE; s_num_ff <= NUM_IDLE; p_num_ff <= NUM_IDLE;
         tmo_ff <= TIMEOUT_RESET;
         idle_ff <= '0; speed_ff <= '0; steer_ff <= '0;
         pval_ff <= '0; neg_ff <= 1'b0; mag_ff <= '0; quo_ff <= '0;
         full_ff <= 1'b0;
         o_speed_ff <= '0; o_steer_ff <= '0;
         o_chk_ff <= 1'b0; o_home_ff <= 1'b0; o_done_ff <= 1'b0;
      end else begin
         if (csr_we) tmo_ff <= csr_wdata;
         full_ff <= res_load || (full_ff && !pop);
         case (st_ff)
            ST_IDLE: begin
               if (ev_take) begin
                  o_chk_ff <= newline_byte && is_chk;
                  o_home_ff <= newline_byte && is_home;
                  o_done_ff <= newline_byte;
                  o_speed_ff <= speed_now;
                  o_steer_ff <= steer_now;
                  speed_ff <= parse_now ? s_val[7:0] : speed_now;
                  steer_ff <= steer_now;
                  pval_ff <= p_val;
                  if (!ev_data.is_byte) idle_ff <= idle_in;
                  else if (ev_data.newline) idle_ff <= '0;
                  if (newline_byte) begin
                     // start a fresh line
                     len_ff <= '0; prev_ff <= '0; sk_ff <= 1'b0; pk_ff <= 1'b0;
                     m_chk_ff <= 1'b1; m_home_ff <= 1'b1;
                     one_ff <= NUM_IDLE; s_num_ff <= NUM_IDLE; p_num_ff <= NUM_IDLE;
                  end else if (store_ch) begin
                     len_ff <= len_ff + LW'(1);
                     prev_ff <= ev_data.ch;
                     sk_ff <= sk_ff || s_hit;
                     pk_ff <= pk_ff || p_hit;
                     one_ff <= one_in; s_num_ff <= s_num_in; p_num_ff <= p_num_in;
                     case (len_ff)
                        LW'(0): begin
                           m_chk_ff <= m_chk_ff && (ev_data.ch == "C");
                           m_home_ff <= m_home_ff && (ev_data.ch == "H");
                        end
                        LW'(1): begin
                           m_chk_ff <= m_chk_ff && (ev_data.ch == "H");
                           m_home_ff <= m_home_ff && (ev_data.ch == "O");
                        end
                        LW'(2): begin
                           m_chk_ff <= m_chk_ff && (ev_data.ch == "K");
                           m_home_ff <= m_home_ff && (ev_data.ch == "M");
                        end
                        LW'(3): m_home_ff <= m_home_ff && (ev_data.ch == "E");
                        default: ;
                     endcase
                  end
                  st_ff <= parse_now ? ST_MUL : ST_IDLE;
               end
            end
            ST_MUL: begin
               neg_ff <= sum[16];
               mag_ff <= 20'({sum_mag, 4'b0000}) + 20'({sum_mag, 2'b00});
               st_ff <= ST_DIV;
            end
            ST_DIV: begin
               quo_ff <= prod[38:23];
               st_ff <= ST_MAP;
            end
            ST_MAP: begin
               steer_ff <= mapped;
               o_steer_ff <= mapped;
               o_speed_ff <= speed_ff;
               st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
